[design/mhpq_pkg.sv]
`timescale 1ns / 1ps
package mhpq_pkg;
  localparam int Capacity = 128;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);
  localparam int IdW = 16;
  localparam int PriW = 4;
  localparam int EntryW = IdW + PriW;
  localparam logic [PriW-1:0] MaxPri = 4'd10;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EX_RD0, S_EX_RDL, S_UP_RD, S_UP_CMP, S_DN_RL, S_DN_RR, S_DN_CMP,
    S_SRCH, S_RESP
  } heap_state_e;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [PriW-1:0] pri;
  } entry_t;
endpackage

[design/mhpq_ram.sv]
`timescale 1ns / 1ps
module mhpq_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [mhpq_pkg::AddrW-1:0] waddr_i,
  input  mhpq_pkg::entry_t          wdata_i,
  input  logic [mhpq_pkg::AddrW-1:0] raddr_i,
  output mhpq_pkg::entry_t          rdata_o
);
  mhpq_pkg::entry_t mem [mhpq_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[design/max_heap_priority_queue.sv]
`timescale 1ns / 1ps
// channel  direction  signals
// in       input      in_valid_i / in_ready_o, operation_i, entry_id_i, priority_req_i
// out      output     out_valid_o / out_ready_i, status_o, out_id_o, out_priority_o, occupancy_o
// one request at a time; the heap ram has a registered read and separate read and write ports
// insert: reads and compares the parent for each level climbed, then checks the children at the final slot
// extract: reads the root and the last entry, then reads and compares both children for each level descended
// update: searches the entries one by one (up to 128), then sifts the found entry
// rst_ni clears the entry count and control; ram contents need no reset
// in_ready_o is low from acceptance until the response is taken
module max_heap_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] entry_id_i,
  input  logic [3:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_id_o,
  output logic [3:0]  out_priority_o,
  output logic [7:0]  occupancy_o
);
  localparam int AW = mhpq_pkg::AddrW;
  localparam int CW = mhpq_pkg::CountW;
  localparam int PW = mhpq_pkg::PriW;

  mhpq_pkg::heap_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  mhpq_pkg::entry_t cur_q, cur_d, l_q, l_d;
  logic [1:0] st_q, st_d;
  logic [15:0] oid_q, oid_d;
  logic [3:0] opr_q, opr_d;
  logic [CW-1:0] srch_q, srch_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  mhpq_pkg::entry_t wdata, rdata;

  mhpq_ram u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [CW:0] lc, rc;
  logic [AW-1:0] par;
  logic lc_ok, rc_ok, take_l, take_r, up_move, found, srch_last, full, empty;
  logic [PW-1:0] pri_clamp;

  assign lc = (CW+1)'({pos_q, 1'b1});
  assign rc = lc + (CW+1)'(1);
  assign par = (pos_q - AW'(1)) >> 1;
  assign lc_ok = lc < (CW+1)'(cnt_q);
  assign rc_ok = rc < (CW+1)'(cnt_q);
  assign take_l = l_q.pri > cur_q.pri;
  assign take_r = rc_ok && (rdata.pri > (take_l ? l_q.pri : cur_q.pri));
  assign up_move = cur_q.pri > rdata.pri;
  assign found = rdata.id == cur_q.id;
  assign srch_last = (srch_q + CW'(1)) >= cnt_q;
  assign full = cnt_q >= CW'(mhpq_pkg::Capacity);
  assign empty = cnt_q == '0;
  assign pri_clamp = (priority_req_i > mhpq_pkg::MaxPri) ? mhpq_pkg::MaxPri : priority_req_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::S_IDLE;
      cnt_q <= '0;
      pos_q <= '0;
      cur_q <= '0;
      l_q <= '0;
      st_q <= '0;
      oid_q <= '0;
      opr_q <= '0;
      srch_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      cur_q <= cur_d;
      l_q <= l_d;
      st_q <= st_d;
      oid_q <= oid_d;
      opr_q <= opr_d;
      srch_q <= srch_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mhpq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (mhpq_pkg::op_e'(operation_i))
            mhpq_pkg::OP_INSERT: state_d = full ? mhpq_pkg::S_RESP : mhpq_pkg::S_UP_RD;
            mhpq_pkg::OP_EXTRACT: state_d = empty ? mhpq_pkg::S_RESP : mhpq_pkg::S_EX_RD0;
            mhpq_pkg::OP_UPDATE: state_d = empty ? mhpq_pkg::S_RESP : mhpq_pkg::S_SRCH;
            default: state_d = mhpq_pkg::S_RESP;
          endcase
        end
      end
      mhpq_pkg::S_EX_RD0: state_d = mhpq_pkg::S_EX_RDL;
      mhpq_pkg::S_EX_RDL: state_d = empty ? mhpq_pkg::S_RESP : mhpq_pkg::S_DN_RL;
      mhpq_pkg::S_UP_RD: state_d = (pos_q == '0) ? mhpq_pkg::S_DN_RL : mhpq_pkg::S_UP_CMP;
      mhpq_pkg::S_UP_CMP: state_d = up_move ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_DN_RL;
      mhpq_pkg::S_DN_RL: state_d = lc_ok ? mhpq_pkg::S_DN_RR : mhpq_pkg::S_RESP;
      mhpq_pkg::S_DN_RR: state_d = mhpq_pkg::S_DN_CMP;
      mhpq_pkg::S_DN_CMP: state_d = (take_r || take_l) ? mhpq_pkg::S_DN_RL : mhpq_pkg::S_RESP;
      mhpq_pkg::S_SRCH: begin
        if (found) state_d = mhpq_pkg::S_UP_RD;
        else if (srch_last) state_d = mhpq_pkg::S_RESP;
      end
      mhpq_pkg::S_RESP: if (out_ready_i) state_d = mhpq_pkg::S_IDLE;
      default: state_d = mhpq_pkg::S_IDLE;
    endcase
  end

  // the moving entry is held in cur_q and written once at its final slot
  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    cur_d = cur_q;
    l_d = l_q;
    st_d = st_q;
    oid_d = oid_q;
    opr_d = opr_q;
    srch_d = srch_q;
    we = 1'b0;
    waddr = pos_q;
    wdata = cur_q;
    raddr = '0;
    case (state_q)
      mhpq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          st_d = 2'(mhpq_pkg::ST_OK);
          oid_d = '0;
          opr_d = '0;
          srch_d = '0;
          cur_d = '{id: entry_id_i, pri: pri_clamp};
          case (mhpq_pkg::op_e'(operation_i))
            mhpq_pkg::OP_INSERT: begin
              if (full) st_d = 2'(mhpq_pkg::ST_FULL);
              else begin
                pos_d = cnt_q[AW-1:0];
                cnt_d = cnt_q + CW'(1);
              end
            end
            mhpq_pkg::OP_EXTRACT: begin
              if (empty) st_d = 2'(mhpq_pkg::ST_EMPTY);
              else cnt_d = cnt_q - CW'(1);
            end
            mhpq_pkg::OP_UPDATE: begin
              if (empty) st_d = 2'(mhpq_pkg::ST_NOT_FOUND);
            end
            default: ;
          endcase
        end
      end
      mhpq_pkg::S_EX_RD0: begin
        oid_d = rdata.id;
        opr_d = rdata.pri;
        raddr = cnt_q[AW-1:0];
      end
      mhpq_pkg::S_EX_RDL: begin
        cur_d = rdata;
        pos_d = '0;
      end
      mhpq_pkg::S_UP_RD: raddr = par;
      mhpq_pkg::S_UP_CMP: begin
        if (up_move) begin
          we = 1'b1;
          wdata = rdata;
          pos_d = par;
        end
      end
      mhpq_pkg::S_DN_RL: begin
        if (lc_ok) raddr = lc[AW-1:0];
        else we = 1'b1;
      end
      mhpq_pkg::S_DN_RR: begin
        l_d = rdata;
        raddr = rc[AW-1:0];
      end
      mhpq_pkg::S_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata = rdata;
          pos_d = rc[AW-1:0];
        end else if (take_l) begin
          wdata = l_q;
          pos_d = lc[AW-1:0];
        end
      end
      mhpq_pkg::S_SRCH: begin
        raddr = AW'(srch_q + CW'(1));
        if (found) pos_d = srch_q[AW-1:0];
        else if (srch_last) st_d = 2'(mhpq_pkg::ST_NOT_FOUND);
        else srch_d = srch_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == mhpq_pkg::S_IDLE);
    out_valid_o = (state_q == mhpq_pkg::S_RESP);
    status_o = st_q;
    out_id_o = oid_q;
    out_priority_o = opr_q;
    occupancy_o = 8'(cnt_q);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(mhpq_pkg::Capacity)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("busy overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != 2'(mhpq_pkg::ST_OK)) |-> (out_id_o == '0))
    else $error("id on error");
endmodule
